/* design/rrps_pkg.sv */
// Shared types and constants of the round-robin process scheduler.
package rrps_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [7:0]  QUANTUM_RST     = 8'd2;
    localparam logic [16:0] STACK_BYTES_RST = 17'd4096;
    localparam logic [31:0] STACK_TOP_RST   = 32'hF000_0000;
    localparam logic [31:0] STACK_ALIGN     = 32'd16;
    localparam logic [31:0] ID_FIRST        = 32'd1;

    localparam logic [1:0] CFG_QUANTUM     = 2'd0;
    localparam logic [1:0] CFG_STACK_BYTES = 2'd1;
    localparam logic [1:0] CFG_REGION_TOP  = 2'd2;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_TERM   = 2'd2,
        CMD_YIELD  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NONE      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CREATE,
        S_HEAD_RD,
        S_DISPATCH,
        S_WALK_RD,
        S_WALK_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] process_id;
        logic [31:0] stack_top;
        logic        dispatched;
        logic [31:0] dispatch_address;
        logic [7:0]  ticks_used;
    } t_rsp;

endpackage

/* design/rrps_req_if.sv */
// Request channel of the scheduler: command and its operands.
interface rrps_req_if;
    import rrps_pkg::*;

    logic        valid;
    logic        ready;
    t_cmd        cmd;
    logic [31:0] entry_address;
    logic [31:0] target_id;

    modport source (output valid, cmd, entry_address, target_id, input ready);
    modport sink   (input valid, cmd, entry_address, target_id, output ready);
endinterface

/* design/rrps_rsp_if.sv */
// Response channel of the scheduler: one result per request.
interface rrps_rsp_if;
    import rrps_pkg::*;

    logic        valid;
    logic        ready;
    t_status     status;
    logic [31:0] process_id;
    logic [31:0] stack_top;
    logic        dispatched;
    logic [31:0] dispatch_address;
    logic [7:0]  ticks_used;

    modport source (output valid, status, process_id, stack_top, dispatched,
                     dispatch_address, ticks_used, input ready);
    modport sink   (input valid, status, process_id, stack_top, dispatched,
                     dispatch_address, ticks_used, output ready);
endinterface

/* design/round_robin_process_scheduler.sv */
// Round-robin process scheduler: process table memories, ready queue and dispatcher.
// Per request: a tick without switch ends in decode; a tick or yield that dispatches
// reads the head, then dispatches; create scans to the lowest free slot, or over all
// SLOTS slots on a full table; terminate walks the queue to the id. One request at a
// time; the free-slot scan over the used bits and the queue walk over the table read
// port set the rate. Synchronous active-low reset clears the slot valid bits and queue
// state at once; the table memories are not cleared and need no clearing pass.
module round_robin_process_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrps_req_if.sink    i_req,
    rrps_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import rrps_pkg::*;

    // Process table: id and entry share one memory, links live in a second
    // one so an enqueue can write a link while the table is read elsewhere.
    logic [63:0]       mem_tab  [SLOTS];
    logic [SLOT_W-1:0] mem_link [SLOTS];

    t_state r_state, n_state;

    // captured request
    t_cmd        r_cmd;
    logic [31:0] r_entry;
    logic [31:0] r_target;

    // configuration
    logic [7:0]  r_quantum;
    logic [16:0] r_stack_bytes;

    // scheduler state
    logic [SLOTS-1:0]  r_used, n_used;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic              r_empty, n_empty;
    logic              r_run_valid, n_run_valid;
    logic [SLOT_W-1:0] r_run_slot, n_run_slot;
    logic [31:0]       r_run_id, n_run_id;
    logic [7:0]        r_ticks, n_ticks;
    logic [31:0]       r_id_ctr, n_id_ctr;
    logic [31:0]       r_cursor, n_cursor;

    // sequencer work registers
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_prev, n_prev;
    t_status           r_status, n_status;
    logic              r_created, n_created;
    logic [31:0]       r_new_id, n_new_id;
    logic              r_disp, n_disp;
    logic [31:0]       r_daddr, n_daddr;

    // memory ports
    logic [SLOT_W-1:0] rd_addr;
    logic [31:0]       r_rd_id;
    logic [31:0]       r_rd_entry;
    logic [SLOT_W-1:0] r_rd_link;
    logic              tab_we;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;

    // shared decode terms
    logic [7:0]  tick_next;
    logic        tick_stay;
    logic        tick_idle;
    logic        term_skip;
    logic        slot_free;
    logic        scan_last;
    logic        walk_hit;
    logic        head_last;
    logic        out_free;
    logic        out_load;
    t_rsp        rsp;

    assign i_req.ready = (r_state == S_IDLE);

    assign tick_next = r_ticks + 8'd1;
    // running and not yet at the quantum: count the tick and keep running
    assign tick_stay = r_run_valid && (tick_next < r_quantum);
    // nothing to do: empty queue, or a yield with no process running
    assign tick_idle = r_empty || ((r_cmd == CMD_YIELD) && !r_run_valid);
    assign term_skip = r_empty || (r_target == 32'd0);
    assign slot_free = !r_used[r_idx];
    assign scan_last = (r_idx == SLOT_W'(SLOTS - 1));
    assign walk_hit  = (r_rd_id == r_target);
    assign head_last = (r_head == r_tail);

    // Table reads: the head for a dispatch, the walk cursor for terminate.
    // Every write of an item lands before the next read is issued, so the
    // sequencer itself keeps read and write of one entry apart.
    assign rd_addr = (r_state == S_WALK_RD) ? r_cur : r_head;

    always_ff @(posedge i_clk) begin
        r_rd_id    <= mem_tab[rd_addr][63:32];
        r_rd_entry <= mem_tab[rd_addr][31:0];
        r_rd_link  <= mem_link[rd_addr];
        if (tab_we) begin
            mem_tab[r_idx] <= {r_id_ctr, r_entry};
        end
        if (link_we) begin
            mem_link[link_waddr] <= link_wdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_cmd)
                    CMD_CREATE: n_state = S_SCAN;
                    CMD_TERM:   n_state = term_skip ? S_DONE : S_WALK_RD;
                    default: begin
                        n_state = (tick_idle || tick_stay) ? S_DONE : S_HEAD_RD;
                    end
                endcase
            end
            S_SCAN: begin
                if (slot_free) begin
                    n_state = S_CREATE;
                end else if (scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_CREATE:   n_state = S_DONE;
            S_HEAD_RD:  n_state = S_DISPATCH;
            S_DISPATCH: n_state = S_DONE;
            S_WALK_RD:  n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                n_state = (walk_hit || (r_cur == r_tail)) ? S_DONE : S_WALK_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_used      = r_used;
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_run_valid = r_run_valid;
        n_run_slot  = r_run_slot;
        n_run_id    = r_run_id;
        n_ticks     = r_ticks;
        n_id_ctr    = r_id_ctr;
        n_cursor    = r_cursor;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_status    = r_status;
        n_created   = r_created;
        n_new_id    = r_new_id;
        n_disp      = r_disp;
        n_daddr     = r_daddr;
        tab_we      = 1'b0;
        link_we     = 1'b0;
        link_waddr  = r_tail;
        link_wdata  = r_idx;
        out_load    = 1'b0;

        case (r_state)
            S_IDLE: begin
                n_created = 1'b0;
                n_disp    = 1'b0;
            end
            S_DECODE: begin
                case (r_cmd)
                    CMD_CREATE: begin
                        n_idx = '0;
                    end
                    CMD_TERM: begin
                        n_status = ST_NOT_FOUND;
                        n_cur    = r_head;
                    end
                    default: begin
                        if (tick_idle) begin
                            n_status = ST_NONE;
                        end else begin
                            n_status = ST_OK;
                            if (tick_stay) begin
                                n_ticks = tick_next;
                            end
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (!slot_free) begin
                    if (scan_last) begin
                        n_status = ST_FULL;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end
            S_CREATE: begin
                // claim the slot, hand out the id, carve an aligned stack
                tab_we         = 1'b1;
                n_used[r_idx]  = 1'b1;
                n_new_id       = r_id_ctr;
                n_id_ctr       = (r_id_ctr == '1) ? ID_FIRST : r_id_ctr + 32'd1;
                n_cursor       = (r_cursor - {15'd0, r_stack_bytes}) & ~(STACK_ALIGN - 32'd1);
                n_status       = ST_OK;
                n_created      = 1'b1;
                // append to the ready queue
                if (r_empty) begin
                    n_head  = r_idx;
                    n_empty = 1'b0;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = r_tail;
                    link_wdata = r_idx;
                end
                n_tail = r_idx;
            end
            S_DISPATCH: begin
                // pop the head, requeue the preempted process at the tail
                if (r_run_valid) begin
                    if (head_last) begin
                        n_head = r_run_slot;
                    end else begin
                        n_head     = r_rd_link;
                        link_we    = 1'b1;
                        link_waddr = r_tail;
                        link_wdata = r_run_slot;
                    end
                    n_tail = r_run_slot;
                end else if (head_last) begin
                    n_empty = 1'b1;
                end else begin
                    n_head = r_rd_link;
                end
                n_run_valid = 1'b1;
                n_run_slot  = r_head;
                n_run_id    = r_rd_id;
                n_ticks     = 8'd0;
                n_disp      = 1'b1;
                n_daddr     = r_rd_entry;
                n_status    = ST_OK;
            end
            S_WALK_CHK: begin
                if (walk_hit) begin
                    // unlink the match and free its slot
                    if (r_cur == r_head) begin
                        if (head_last) begin
                            n_empty = 1'b1;
                        end else begin
                            n_head = r_rd_link;
                        end
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_prev;
                        link_wdata = r_rd_link;
                        if (r_cur == r_tail) begin
                            n_tail = r_prev;
                        end
                    end
                    n_used[r_cur] = 1'b0;
                    n_status      = ST_OK;
                end else begin
                    n_prev = r_cur;
                    n_cur  = r_rd_link;
                end
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // result assembly
    always_comb begin
        rsp.status           = r_status;
        rsp.process_id       = r_created ? r_new_id : (r_run_valid ? r_run_id : 32'd0);
        rsp.stack_top        = r_created ? r_cursor + {15'd0, r_stack_bytes} : 32'd0;
        rsp.dispatched       = r_disp;
        rsp.dispatch_address = r_disp ? r_daddr : 32'd0;
        rsp.ticks_used       = r_run_valid ? r_ticks : 8'd0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_used        <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_empty       <= 1'b1;
            r_run_valid   <= 1'b0;
            r_ticks       <= 8'd0;
            r_id_ctr      <= ID_FIRST;
            r_cursor      <= STACK_TOP_RST;
            r_quantum     <= QUANTUM_RST;
            r_stack_bytes <= STACK_BYTES_RST;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_run_valid <= n_run_valid;
            r_ticks     <= n_ticks;
            r_id_ctr    <= n_id_ctr;
            r_cursor    <= n_cursor;
            // the region top reloads the cursor only from its reset value,
            // so a write to it is taken and dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_QUANTUM:     r_quantum     <= i_cfg_data[7:0];
                    CFG_STACK_BYTES: r_stack_bytes <= i_cfg_data[16:0];
                    CFG_REGION_TOP:  r_stack_bytes <= r_stack_bytes;
                    default:         r_quantum     <= r_quantum;
                endcase
            end
        end
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd    <= i_req.cmd;
            r_entry  <= i_req.entry_address;
            r_target <= i_req.target_id;
        end
        r_run_slot <= n_run_slot;
        r_run_id   <= n_run_id;
        r_idx      <= n_idx;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_status   <= n_status;
        r_created  <= n_created;
        r_new_id   <= n_new_id;
        r_disp     <= n_disp;
        r_daddr    <= n_daddr;
    end

    rrps_rsp_reg u_rsp_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_rsp   (rsp),
        .o_free  (out_free),
        .o_rsp   (o_rsp)
    );
endmodule

/* design/rrps_rsp_reg.sv */
// One-entry output register that holds a finished result until it is taken.
module rrps_rsp_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rrps_pkg::t_rsp   i_rsp,
    output logic             o_free,
    rrps_rsp_if.source       o_rsp
);
    import rrps_pkg::*;

    logic r_valid;
    t_rsp r_rsp;

    assign o_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload loads only on a free slot, so a stalled result holds
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid            = r_valid;
    assign o_rsp.status           = r_rsp.status;
    assign o_rsp.process_id       = r_rsp.process_id;
    assign o_rsp.stack_top        = r_rsp.stack_top;
    assign o_rsp.dispatched       = r_rsp.dispatched;
    assign o_rsp.dispatch_address = r_rsp.dispatch_address;
    assign o_rsp.ticks_used       = r_rsp.ticks_used;
endmodule

/* design/rrps_checker.sv */
// Port-level assertions for the scheduler and their bind to the top level.
module rrps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input rrps_pkg::t_status   i_status,
    input logic [31:0]         i_process_id,
    input logic [31:0]         i_stack_top,
    input logic                i_dispatched,
    input logic [7:0]          i_ticks_used
);
    import rrps_pkg::*;

    // one request in flight: ready drops right after an accept
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_process_id) && $stable(i_dispatched))
        else $error("stalled result changed");

    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_dispatched |-> (i_status == ST_OK) && (i_process_id != 32'd0))
        else $error("dispatch without ok status or running id");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_process_id == 32'd0) |-> (i_ticks_used == 8'd0)
            && (i_stack_top == 32'd0))
        else $error("tick count or stack without a process");
endmodule

bind round_robin_process_scheduler rrps_checker u_rrps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_process_id (o_rsp.process_id),
    .i_stack_top  (o_rsp.stack_top),
    .i_dispatched (o_rsp.dispatched),
    .i_ticks_used (o_rsp.ticks_used)
);
